### src/cclb_pkg.sv
// Package for the clipped color-key blitter: configuration register layout,
// register indexes, opcodes and field widths.
// Depends on nothing; every other source file imports it.
package cclb_pkg;

	// Field and register widths fixed by the item format.
	localparam int unsigned PIX_W   = 8;
	localparam int unsigned POS_W   = 10;
	localparam int unsigned COORD_W = 16;
	localparam int unsigned KEY_W   = 9;
	localparam int unsigned ADDR_W  = 16;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned IDX_W   = 3;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_DEST_X          = 3'd0;
	localparam logic [IDX_W-1:0] REG_DEST_Y          = 3'd1;
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd2;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd3;
	localparam logic [IDX_W-1:0] REG_TRANSPARENT_KEY = 3'd4;
	localparam logic [IDX_W-1:0] REG_LUT_ENABLE      = 3'd5;

	// Input item kinds carried on tuser.
	localparam logic OP_PIXEL     = 1'b0;
	localparam logic OP_LUT_WRITE = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [POS_W-1:0] IMAGE_SIZE_RESET = 10'd24;

	// Default screen geometry.
	localparam int unsigned DEF_SCREEN_WIDTH  = 320;
	localparam int unsigned DEF_SCREEN_HEIGHT = 200;
	localparam int unsigned DEF_LINE_STRIDE   = 320;

	// All configuration registers, handed to the submodules as one group.
	typedef struct packed {
		logic signed [COORD_W-1:0] dest_x;
		logic signed [COORD_W-1:0] dest_y;
		logic [POS_W-1:0]          image_width;
		logic [POS_W-1:0]          image_height;
		logic signed [KEY_W-1:0]   transparent_key;
		logic                      lut_enable;
	} cfg_t;

endpackage

### src/clipped_colorkey_lut_blitter.sv
// Top level of the clipped color-key blitter with palette lookup.
// Depends on cclb_pkg, cclb_pos, cclb_lut and cclb_place.
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  tdata: frame_start, pixel, lut index/data; tuser: op
//   m_*      out        m_tvalid/m_tready  tdata: fb_address, fb_data
//   cfg_*    in         cfg_we             cfg_index, cfg_data
//
// One beat is accepted every cycle unless both stages are full; a kept pixel
// passes the input stage with the palette read, then the output register.
// Table writes and dropped pixels produce no output beat.
// Reset clears the position and the valid flags and resets the configuration
// registers; the palette holds no defined values until it is written.
// A stalled output holds its beat and backs up into the input stage, and the
// input is refused only while both stages are full.
module clipped_colorkey_lut_blitter #(
	parameter int unsigned SCREEN_WIDTH  = cclb_pkg::DEF_SCREEN_WIDTH,
	parameter int unsigned SCREEN_HEIGHT = cclb_pkg::DEF_SCREEN_HEIGHT,
	parameter int unsigned LINE_STRIDE   = cclb_pkg::DEF_LINE_STRIDE
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// [0] frame_start, [8:1] pixel_value, [16:9] lut_index, [24:17] lut_data, [31:25] zero
	input  logic [31:0]                 s_tdata,
	// [0] opcode
	input  logic                        s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [15:0] fb_address, [23:16] fb_data
	output logic [23:0]                 m_tdata,
	input  logic                        cfg_we,
	input  logic [cclb_pkg::IDX_W-1:0]  cfg_index,
	input  logic [cclb_pkg::CFG_W-1:0]  cfg_data
);
	import cclb_pkg::*;

	cfg_t cfg_q;

	logic             in_fire;
	logic             pix_fire;
	logic             lut_fire;
	logic             in_frame_start;
	logic [PIX_W-1:0] in_pixel;
	logic [PIX_W-1:0] in_lut_index;
	logic [PIX_W-1:0] in_lut_data;
	logic [POS_W-1:0] cur_col;
	logic [POS_W-1:0] cur_row;

	logic             s1_valid_q;
	logic [PIX_W-1:0] px_s1;
	logic [POS_W-1:0] col_s1;
	logic [POS_W-1:0] row_s1;
	logic [PIX_W-1:0] lut_s1;

	logic              place_keep;
	logic [ADDR_W-1:0] place_addr;
	logic [PIX_W-1:0]  place_data;

	logic              out_valid_q;
	logic              out_free;
	logic [ADDR_W-1:0] fb_address_q;
	logic [PIX_W-1:0]  fb_data_q;

	// Unpack the input beat.
	assign in_frame_start = s_tdata[0];
	assign in_pixel       = s_tdata[8:1];
	assign in_lut_index   = s_tdata[16:9];
	assign in_lut_data    = s_tdata[24:17];

	// Flow control: the output register frees when taken, the input stage when
	// its pixel moves on.
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !s1_valid_q || out_free;
	assign in_fire  = s_tvalid && s_tready;
	assign pix_fire = in_fire && (s_tuser == OP_PIXEL);
	assign lut_fire = in_fire && (s_tuser == OP_LUT_WRITE);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_x          <= '0;
			cfg_q.dest_y          <= '0;
			cfg_q.image_width     <= IMAGE_SIZE_RESET;
			cfg_q.image_height    <= IMAGE_SIZE_RESET;
			cfg_q.transparent_key <= '0;
			cfg_q.lut_enable      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEST_X:          cfg_q.dest_x          <= cfg_data;
				REG_DEST_Y:          cfg_q.dest_y          <= cfg_data;
				REG_IMAGE_WIDTH:     cfg_q.image_width     <= cfg_data[POS_W-1:0];
				REG_IMAGE_HEIGHT:    cfg_q.image_height    <= cfg_data[POS_W-1:0];
				REG_TRANSPARENT_KEY: cfg_q.transparent_key <= cfg_data[KEY_W-1:0];
				REG_LUT_ENABLE:      cfg_q.lut_enable      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Raster position of incoming pixels.
	cclb_pos u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.advance     (pix_fire),
		.frame_start (in_frame_start),
		.cur_col     (cur_col),
		.cur_row     (cur_row)
	);

	// Palette memory: written by table beats, read for every pixel.
	cclb_lut u_lut (
		.clk     (clk),
		.wr_en   (lut_fire),
		.wr_addr (in_lut_index),
		.wr_data (in_lut_data),
		.rd_en   (pix_fire),
		.rd_addr (in_pixel),
		.rd_data (lut_s1)
	);

	// Input stage: holds one accepted pixel and its position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= pix_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_fire) begin
			px_s1  <= in_pixel;
			col_s1 <= cur_col;
			row_s1 <= cur_row;
		end
	end

	// Clip, key and address for the staged pixel.
	cclb_place #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.LINE_STRIDE   (LINE_STRIDE)
	) u_place (
		.cfg        (cfg_q),
		.col        (col_s1),
		.row        (row_s1),
		.pixel      (px_s1),
		.lut_value  (lut_s1),
		.keep       (place_keep),
		.fb_address (place_addr),
		.fb_data    (place_data)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_q && place_keep;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_valid_q && place_keep) begin
			fb_address_q <= place_addr;
			fb_data_q    <= place_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {fb_data_q, fb_address_q};

	// A table beat never occupies the pixel stage.
	a_lut_not_staged: assert property (@(posedge clk) disable iff (!arst_n)
		lut_fire |=> !s1_valid_q)
		else $error("table write entered the pixel stage");

	// A kept pixel that moves on always produces an output beat.
	a_keep_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && place_keep && out_free) |=> m_tvalid)
		else $error("kept pixel lost");

	// The input is never refused while the pixel stage is empty.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> s_tready)
		else $error("input stalled with empty stage");

	// A dropped pixel that moves on leaves the output empty.
	a_drop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !place_keep && out_free) |=> !m_tvalid)
		else $error("dropped pixel produced a beat");

endmodule

### src/cclb_pos.sv
// Source position tracker: keeps the raster column and row of the image.
// Depends on cclb_pkg.
module cclb_pos (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cclb_pkg::cfg_t               cfg,
	input  logic                         advance,
	input  logic                         frame_start,
	output logic [cclb_pkg::POS_W-1:0]   cur_col,
	output logic [cclb_pkg::POS_W-1:0]   cur_row
);
	import cclb_pkg::*;

	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic [POS_W-1:0] col_d;
	logic [POS_W-1:0] row_d;
	logic [POS_W:0]   next_col;
	logic [POS_W:0]   next_row;

	// Position of the pixel now being accepted; a frame start restarts at the origin.
	assign cur_col = frame_start ? '0 : col_q;
	assign cur_row = frame_start ? '0 : row_q;

	// Step the column, wrap to the next row at the image width and to the top
	// at the image height. A zero size wraps like a size of one.
	always_comb begin
		next_col = {1'b0, cur_col} + 1'b1;
		next_row = {1'b0, cur_row} + 1'b1;
		if (next_col >= {1'b0, cfg.image_width}) begin
			col_d = '0;
			row_d = (next_row >= {1'b0, cfg.image_height}) ? '0 : next_row[POS_W-1:0];
		end else begin
			col_d = next_col[POS_W-1:0];
			row_d = cur_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

endmodule

### src/cclb_lut.sv
// Palette lookup memory: 256 entries of 8 bits, one write and one
// registered read per cycle. Depends on cclb_pkg.
module cclb_lut (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [cclb_pkg::PIX_W-1:0]  wr_addr,
	input  logic [cclb_pkg::PIX_W-1:0]  wr_data,
	input  logic                        rd_en,
	input  logic [cclb_pkg::PIX_W-1:0]  rd_addr,
	output logic [cclb_pkg::PIX_W-1:0]  rd_data
);
	import cclb_pkg::*;

	localparam int unsigned DEPTH = 1 << PIX_W;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rd_data_s1;

	// Table-write beats load one entry.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// The entry for an accepted pixel is read into the first stage.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_s1;

endmodule

### src/cclb_place.sv
// Placement, clipping, color keying and address generation for one pixel.
// Depends on cclb_pkg.
module cclb_place #(
	parameter int unsigned SCREEN_WIDTH  = cclb_pkg::DEF_SCREEN_WIDTH,
	parameter int unsigned SCREEN_HEIGHT = cclb_pkg::DEF_SCREEN_HEIGHT,
	parameter int unsigned LINE_STRIDE   = cclb_pkg::DEF_LINE_STRIDE
) (
	input  cclb_pkg::cfg_t                cfg,
	input  logic [cclb_pkg::POS_W-1:0]    col,
	input  logic [cclb_pkg::POS_W-1:0]    row,
	input  logic [cclb_pkg::PIX_W-1:0]    pixel,
	input  logic [cclb_pkg::PIX_W-1:0]    lut_value,
	output logic                          keep,
	output logic [cclb_pkg::ADDR_W-1:0]   fb_address,
	output logic [cclb_pkg::PIX_W-1:0]    fb_data
);
	import cclb_pkg::*;

	localparam int unsigned SC_W = COORD_W + 2;
	localparam logic signed [SC_W-1:0] SCR_W = SC_W'(SCREEN_WIDTH);
	localparam logic signed [SC_W-1:0] SCR_H = SC_W'(SCREEN_HEIGHT);
	localparam logic [ADDR_W-1:0]      STRIDE = ADDR_W'(LINE_STRIDE);

	logic signed [SC_W-1:0] dx;
	logic signed [SC_W-1:0] dy;
	logic                   on_screen;
	logic                   keyed_out;
	logic [ADDR_W-1:0]      row_base;

	// Screen position of the pixel, wide enough that it cannot overflow.
	assign dx = SC_W'(cfg.dest_x) + $signed({(SC_W - POS_W)'(0), col});
	assign dy = SC_W'(cfg.dest_y) + $signed({(SC_W - POS_W)'(0), row});

	// Clip against the screen and drop the transparent index unless keying is off.
	assign on_screen = (dx >= 0) && (dx < SCR_W) && (dy >= 0) && (dy < SCR_H);
	assign keyed_out = !cfg.transparent_key[KEY_W-1]
		&& (cfg.transparent_key[PIX_W-1:0] == pixel);
	assign keep = on_screen && !keyed_out;

	// Only the low 16 bits of the address are kept, so a 16-bit product suffices.
	assign row_base   = dy[ADDR_W-1:0] * STRIDE;
	assign fb_address = row_base + dx[ADDR_W-1:0];
	assign fb_data    = cfg.lut_enable ? lut_value : pixel;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for the clipped color-key blitter: a queue-fed stream driver, a stalling
// receiver and an in-line framebuffer-write predictor that checks every output beat.
// Depends on cclb_pkg and clipped_colorkey_lut_blitter.
module testbench;
	import cclb_pkg::*;

	localparam int SCREEN_W    = DEF_SCREEN_WIDTH;
	localparam int SCREEN_H    = DEF_SCREEN_HEIGHT;
	localparam int STRIDE      = DEF_LINE_STRIDE;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_EVERY  = 700;
	localparam int HOLD_LEN    = 64;

	typedef struct packed {
		logic       opcode;
		logic       frame_start;
		logic [7:0] pixel;
		logic [7:0] lut_idx;
		logic [7:0] lut_val;
	} blit_beat_t;

	typedef struct packed {
		logic [15:0] addr;
		logic [7:0]  data;
	} fb_write_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [31:0]        s_tdata;
	logic               s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [23:0]        m_tdata;
	logic               cfg_we;
	logic [IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]   cfg_data;

	// Beats waiting for the driver, and framebuffer writes waiting for the output.
	blit_beat_t pend_beats[$];
	fb_write_t  fb_write_q[$];
	blit_beat_t cur_beat;
	bit         s_taken;

	// Predictor copy of the configuration, source position and palette.
	int         cfg_dx;
	int         cfg_dy;
	int         cfg_w;
	int         cfg_h;
	int         cfg_key;
	bit         cfg_lut;
	int         pos_col;
	int         pos_row;
	bit [7:0]   pal_mem [256];

	// Palette entries the stimulus has loaded so far.
	bit         loaded [256];
	int         loaded_idx[$];

	int         err_count;
	int         beats_sent;
	int         beats_pushed;
	int         table_writes;
	int         fb_checked;
	int         cfg_writes;
	int         phases_run;
	int         cyc_count;
	int         burst_left;
	int         gap_left;
	int         rx_cycle;
	int         hold_timer;
	int         hold_left;
	int         holds_done;
	logic       rx_ready;

	clipped_colorkey_lut_blitter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch on write %0d: %s got %h, want %h", fb_checked, what, got, want);
		err_count++;
	endtask

	// Place one accepted beat: table writes load the palette, pixels are clipped,
	// keyed and possibly mapped, and every pixel advances the position.
	task automatic blit_step(input blit_beat_t b);
		int        sx;
		int        sy;
		int        full_addr;
		bit        keep;
		fb_write_t w;
		if (b.opcode == OP_LUT_WRITE) begin
			pal_mem[b.lut_idx] = b.lut_val;
			table_writes++;
		end else begin
			if (b.frame_start) begin
				pos_col = 0;
				pos_row = 0;
			end
			sx = cfg_dx + pos_col;
			sy = cfg_dy + pos_row;
			keep = sx >= 0 && sx < SCREEN_W && sy >= 0 && sy < SCREEN_H;
			if (keep && cfg_key >= 0 && int'(b.pixel) == cfg_key)
				keep = 1'b0;
			// A zero size compares as one; a position beyond a shrunk size wraps here.
			if (pos_col + 1 >= cfg_w) begin
				pos_col = 0;
				pos_row = (pos_row + 1 >= cfg_h) ? 0 : pos_row + 1;
			end else begin
				pos_col = pos_col + 1;
			end
			if (keep) begin
				full_addr = sy * STRIDE + sx;
				w.addr = full_addr[15:0];
				w.data = cfg_lut ? pal_mem[b.pixel] : b.pixel;
				fb_write_q.push_back(w);
			end
		end
		beats_sent++;
	endtask

	// Output check first, then the input beat, so a same-edge push never meets a pop.
	always @(posedge clk) begin
		fb_write_t want;
		s_taken = 1'b0;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (fb_write_q.size() == 0) begin
					report_mismatch("unexpected write, address", m_tdata[15:0], 16'd0);
				end else begin
					want = fb_write_q.pop_front();
					if (m_tdata[15:0] !== want.addr)
						report_mismatch("fb_address", m_tdata[15:0], want.addr);
					if (m_tdata[23:16] !== want.data)
						report_mismatch("fb_data", {8'd0, m_tdata[23:16]}, {8'd0, want.data});
				end
				fb_checked++;
			end
			if (s_tvalid && s_tready) begin
				s_taken = 1'b1;
				blit_step(cur_beat);
			end
		end
	end

	// Sender: bursts of random length separated by random gaps, some with no gap.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pend_beats.size() > 0) begin
				cur_beat = pend_beats.pop_front();
				s_tdata  <= {7'd0, cur_beat.lut_val, cur_beat.lut_idx, cur_beat.pixel,
					cur_beat.frame_start};
				s_tuser  <= cur_beat.opcode;
				s_tvalid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 23);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: a rotating stall pattern, plus a long hold-off now and then while
	// the sender keeps offering beats, so both pipeline stages fill up.
	always @(negedge clk) begin
		rx_cycle++;
		hold_timer++;
		if (hold_left > 0) begin
			hold_left--;
			rx_ready = 1'b0;
		end else if (hold_timer >= HOLD_EVERY && s_tvalid) begin
			hold_timer = 0;
			hold_left = HOLD_LEN;
			holds_done++;
			rx_ready = 1'b0;
		end else begin
			case ((rx_cycle / 150) % 4)
				0: rx_ready = 1'b1;
				1: rx_ready = 1'($urandom_range(0, 1));
				2: rx_ready = ($urandom_range(0, 3) == 0);
				default: rx_ready = (rx_cycle % 7) < 4;
			endcase
		end
		m_tready <= arst_n ? rx_ready : 1'b0;
	end

	always @(posedge clk) begin
		cyc_count++;
		if (cyc_count >= CYCLE_LIMIT) begin
			$display("testbench: cycle limit hit, %0d writes still expected", fb_write_q.size());
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Register write at the falling edge; the predictor copy follows at once.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		case (idx)
			REG_DEST_X:          cfg_dx = int'($signed(val));
			REG_DEST_Y:          cfg_dy = int'($signed(val));
			REG_IMAGE_WIDTH:     cfg_w = int'(val[POS_W-1:0]);
			REG_IMAGE_HEIGHT:    cfg_h = int'(val[POS_W-1:0]);
			REG_TRANSPARENT_KEY: cfg_key = int'($signed(val[KEY_W-1:0]));
			REG_LUT_ENABLE:      cfg_lut = val[0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic write_all(input int dx, input int dy, input int w, input int h,
			input int key, input bit lut);
		write_reg(REG_DEST_X, 16'(dx));
		write_reg(REG_DEST_Y, 16'(dy));
		write_reg(REG_IMAGE_WIDTH, 16'(w));
		write_reg(REG_IMAGE_HEIGHT, 16'(h));
		write_reg(REG_TRANSPARENT_KEY, 16'(key) & 16'h01FF);
		write_reg(REG_LUT_ENABLE, {15'd0, lut});
	endtask

	task automatic push_pixel(input logic fs, input logic [7:0] px);
		blit_beat_t b;
		b = '{opcode: OP_PIXEL, frame_start: fs, pixel: px,
			lut_idx: 8'($urandom), lut_val: 8'($urandom)};
		pend_beats.push_back(b);
		beats_pushed++;
	endtask

	task automatic push_table(input logic [7:0] idx, input logic [7:0] val,
			input logic fs, input logic [7:0] px);
		blit_beat_t b;
		b = '{opcode: OP_LUT_WRITE, frame_start: fs, pixel: px, lut_idx: idx, lut_val: val};
		pend_beats.push_back(b);
		beats_pushed++;
		if (!loaded[idx]) begin
			loaded[idx] = 1'b1;
			loaded_idx.push_back(idx);
		end
	endtask

	// Pixel values lean on the key; with the palette on only loaded entries are used.
	function automatic logic [7:0] pick_pixel();
		if (cfg_key >= 0 && $urandom_range(0, 4) == 0 && (!cfg_lut || loaded[cfg_key]))
			return 8'(cfg_key);
		if (cfg_lut)
			return 8'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]);
		return 8'($urandom_range(0, 255));
	endfunction

	// Wait until every queued beat has been accepted and every expected write
	// has come out, then let the two stages settle.
	task automatic wait_idle();
		while (pend_beats.size() != 0 || beats_sent != beats_pushed || s_tvalid
				|| fb_write_q.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
		phases_run++;
	endtask

	// One random setting, then mostly whole raster frames with table writes and
	// stray frame starts mixed in.
	task automatic run_random_phase(input int n_items);
		int sel;
		int dx;
		int dy;
		int w;
		int h;
		int key;
		int r;
		int frame_len;
		int fcount;
		bit lut;
		logic fs;
		sel = $urandom_range(0, 99);
		if (sel < 65) w = $urandom_range(1, 40);
		else if (sel < 80) w = $urandom_range(41, 400);
		else if (sel < 92) w = 1023;
		else w = 1;
		sel = $urandom_range(0, 99);
		if (sel < 70) h = $urandom_range(1, 24);
		else if (sel < 85) h = $urandom_range(25, 300);
		else if (sel < 93) h = 1023;
		else h = 1;
		sel = $urandom_range(0, 99);
		if (sel < 75) dx = $urandom_range(0, 380) - 40;
		else if (sel < 83) dx = -32768;
		else if (sel < 91) dx = 32767;
		else dx = int'($signed(16'($urandom)));
		sel = $urandom_range(0, 99);
		if (sel < 75) dy = $urandom_range(0, 260) - 40;
		else if (sel < 83) dy = -32768;
		else if (sel < 91) dy = 32767;
		else dy = int'($signed(16'($urandom)));
		sel = $urandom_range(0, 99);
		if (sel < 40) key = -1;
		else if (sel < 50) key = -$urandom_range(2, 256);
		else key = $urandom_range(0, 255);
		lut = loaded_idx.size() > 0 && $urandom_range(0, 1);
		write_all(dx, dy, w, h, key, lut);

		frame_len = w * h;
		fcount = frame_len;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				push_table(8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
			end else begin
				fs = (fcount >= frame_len) || (r >= 97);
				if (fs)
					fcount = 0;
				fcount++;
				push_pixel(fs, pick_pixel());
			end
		end
		wait_idle();
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = OP_PIXEL;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_DEST_X;
		cfg_data  = '0;
		cfg_dx    = 0;
		cfg_dy    = 0;
		cfg_w     = int'(IMAGE_SIZE_RESET);
		cfg_h     = int'(IMAGE_SIZE_RESET);
		cfg_key   = 0;
		cfg_lut   = 1'b0;
		pos_col   = 0;
		pos_row   = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset setting: table writes carry junk in the ignored fields, and a
		// pixel equal to the default key of zero is dropped.
		push_table(8'h00, 8'hFF, 1'b1, 8'hFF);
		push_table(8'hFF, 8'h00, 1'b0, 8'h00);
		push_table(8'hAA, 8'h55, 1'b1, 8'h55);
		push_table(8'h55, 8'hAA, 1'b0, 8'hAA);
		push_pixel(1'b1, 8'h00);
		push_pixel(1'b0, 8'hFF);
		push_pixel(1'b0, 8'hAA);
		push_pixel(1'b0, 8'h55);
		push_pixel(1'b0, 8'h01);
		wait_idle();

		// Zero image size at the bottom-right screen corner, keying disabled,
		// palette on: every pixel lands on the same spot.
		write_all(SCREEN_W - 1, SCREEN_H - 1, 0, 0, -1, 1'b1);
		push_pixel(1'b1, 8'h00);
		push_pixel(1'b0, 8'hFF);
		push_pixel(1'b0, 8'hAA);
		wait_idle();

		// A 3x2 image hanging off the top-left corner with key 255; the palette
		// entry read by the one kept pixel is rewritten just ahead of it.
		write_reg(REG_DEST_X, 16'hFFFF);
		write_reg(REG_DEST_Y, 16'hFFFF);
		write_reg(REG_IMAGE_WIDTH, 16'd3);
		write_reg(REG_IMAGE_HEIGHT, 16'd2);
		write_reg(REG_TRANSPARENT_KEY, 16'h00FF);
		push_pixel(1'b1, 8'h00);
		push_pixel(1'b0, 8'hFF);
		push_pixel(1'b0, 8'hAA);
		push_pixel(1'b0, 8'h55);
		push_table(8'h00, 8'h12, 1'b0, 8'h00);
		push_pixel(1'b0, 8'h00);
		push_pixel(1'b0, 8'hFF);
		push_pixel(1'b0, 8'hAA);
		wait_idle();

		// Shrink the image mid-blit: the column left beyond it wraps on the next pixel.
		write_reg(REG_DEST_X, 16'd0);
		write_reg(REG_DEST_Y, 16'd0);
		write_reg(REG_IMAGE_WIDTH, 16'd1);
		write_reg(REG_IMAGE_HEIGHT, 16'd1);
		push_pixel(1'b0, 8'hAA);
		push_pixel(1'b0, 8'h55);
		wait_idle();

		// Extreme offsets and sizes with a negative key other than -1: all clipped.
		write_all(32767, -32768, 1023, 1023, -256, 1'b0);
		push_pixel(1'b1, 8'h80);
		push_pixel(1'b0, 8'h7F);
		wait_idle();

		for (int p = 0; p < 12; p++)
			run_random_phase(65);

		$display("testbench: %0d beats (%0d table writes) over %0d settings, %0d reg writes",
			beats_sent, table_writes, phases_run, cfg_writes);
		$display("testbench: %0d framebuffer writes checked, %0d long output hold-offs",
			fb_checked, holds_done);
		if (err_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
